### design/ashc_pkg.sv
// ashc_pkg: shared types and constants for the asymmetric soft/hard clipper
// holds the register map, the config struct and the knee operation codes
// no dependencies
`timescale 1ns / 1ps

package ashc_pkg;

  // register indexes on the config port
  localparam logic [2:0] REG_CLIP_MODE  = 3'd0;
  localparam logic [2:0] REG_DRIVE      = 3'd1;
  localparam logic [2:0] REG_POS_THR    = 3'd2;
  localparam logic [2:0] REG_NEG_THR    = 3'd3;
  localparam logic [2:0] REG_HARD_THR   = 3'd4;
  localparam logic [2:0] REG_POST_SLOPE = 3'd5;

  // register reset values
  localparam logic [15:0] DRIVE_RST      = 16'd2048;
  localparam logic [15:0] POS_THR_RST    = 16'd20316;
  localparam logic [15:0] NEG_THR_RST    = 16'd21955;
  localparam logic [15:0] HARD_THR_RST   = 16'd32768;
  localparam logic [15:0] POST_SLOPE_RST = 16'd0;

  // drive is Q5.11: unity and the 30.0 cap
  localparam logic [15:0] DRIVE_ONE = 16'd2048;
  localparam logic [15:0] DRIVE_MAX = 16'd61440;

  // knee denominator is formed in Q.24
  localparam int KNEE_FRAC = 24;
  // scaled excess width (excess below 32.0 in Q.24)
  localparam int EKW = 29;
  // denominator width (1 + e^2 below 2^11 in Q.24)
  localparam int DW = 35;

  // what the last stage does with the knee quotient
  typedef enum logic [1:0] {
    OP_PASS,
    OP_ADD,
    OP_SUB
  } knee_op_t;

  typedef struct packed {
    logic        clip_mode;
    logic [15:0] drive;
    logic [15:0] pos_thr;
    logic [15:0] neg_thr;
    logic [15:0] hard_thr;
    logic [15:0] post_slope;
  } cfg_t;

endpackage

### design/ashc_regs.sv
// ashc_regs: APB-style config register file of the clipper
// depends on ashc_pkg (register map, cfg_t)
`timescale 1ns / 1ps

module ashc_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ashc_pkg::cfg_t     cfg
);

  ashc_pkg::cfg_t cfg_r;
  ashc_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [2:0]     idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // write decode, drive clamped to 30.0
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        ashc_pkg::REG_CLIP_MODE:  cfg_nxt.clip_mode = pwdata[0];
        ashc_pkg::REG_DRIVE: begin
          if (pwdata[15:0] > ashc_pkg::DRIVE_MAX) begin
            cfg_nxt.drive = ashc_pkg::DRIVE_MAX;
          end else begin
            cfg_nxt.drive = pwdata[15:0];
          end
        end
        ashc_pkg::REG_POS_THR:    cfg_nxt.pos_thr    = pwdata[15:0];
        ashc_pkg::REG_NEG_THR:    cfg_nxt.neg_thr    = pwdata[15:0];
        ashc_pkg::REG_HARD_THR:   cfg_nxt.hard_thr   = pwdata[15:0];
        ashc_pkg::REG_POST_SLOPE: cfg_nxt.post_slope = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_mode  <= 1'b0;
      cfg_r.drive      <= ashc_pkg::DRIVE_RST;
      cfg_r.pos_thr    <= ashc_pkg::POS_THR_RST;
      cfg_r.neg_thr    <= ashc_pkg::NEG_THR_RST;
      cfg_r.hard_thr   <= ashc_pkg::HARD_THR_RST;
      cfg_r.post_slope <= ashc_pkg::POST_SLOPE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read back
  always_comb begin
    case (idx)
      ashc_pkg::REG_CLIP_MODE:  prdata = {31'd0, cfg_r.clip_mode};
      ashc_pkg::REG_DRIVE:      prdata = {16'd0, cfg_r.drive};
      ashc_pkg::REG_POS_THR:    prdata = {16'd0, cfg_r.pos_thr};
      ashc_pkg::REG_NEG_THR:    prdata = {16'd0, cfg_r.neg_thr};
      ashc_pkg::REG_HARD_THR:   prdata = {16'd0, cfg_r.hard_thr};
      ashc_pkg::REG_POST_SLOPE: prdata = {16'd0, cfg_r.post_slope};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

### design/ashc_front.sv
// ashc_front: five-stage front end of the clipper
// drive gain, knee select, hard clip, excess squaring, divider operands
// depends on ashc_pkg (cfg_t, knee_op_t, knee constants)
`timescale 1ns / 1ps

module ashc_front #(
  parameter int W = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ashc_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  input  logic signed [W-1:0]    in_x,
  output logic                   out_valid,
  output logic [W+35:0]          out_rem,
  output logic [ashc_pkg::DW-1:0] out_den,
  output logic signed [W+5:0]    out_base,
  output ashc_pkg::knee_op_t     out_op
);

  localparam int F  = W - 1;
  localparam int BW = W + 6;
  localparam int EW = F + 5;
  localparam int CW = W + 36;
  localparam int DW = ashc_pkg::DW;
  localparam int EKW = ashc_pkg::EKW;
  localparam int KF = ashc_pkg::KNEE_FRAC;

  // stage 0: input capture
  logic                  v0_r;
  logic signed [W-1:0]   x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
    x_r <= in_x;
  end

  // stage 1: drive gain and hard clip excess
  logic signed [W+16:0]  dprod;
  logic signed [W+16:0]  dround;
  logic signed [BW-1:0]  xs_nxt;
  logic signed [W+1:0]   t;
  logic signed [W+1:0]   xe;
  logic signed [W+1:0]   d_nxt;
  logic signed [BW-1:0]  hb_nxt;
  logic                  v1_r;
  logic signed [BW-1:0]  xs_r;
  logic signed [W+1:0]   d_r;
  logic signed [BW-1:0]  hb_r;

  always_comb begin
    dprod  = x_r * $signed({1'b0, cfg.drive});
    dround = dprod + $signed((W+17)'(1024));
    if (cfg.drive > ashc_pkg::DRIVE_ONE) begin
      xs_nxt = BW'(dround >>> 11);
    end else begin
      xs_nxt = BW'(x_r);
    end
    t  = $signed((W+2)'(cfg.hard_thr) << (F - 15));
    xe = (W+2)'(x_r);
    if (xe > t) begin
      d_nxt  = xe - t;
      hb_nxt = BW'(t);
    end else if (xe < -t) begin
      d_nxt  = xe + t;
      hb_nxt = -BW'(t);
    end else begin
      d_nxt  = '0;
      hb_nxt = BW'(xe);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    xs_r <= xs_nxt;
    d_r  <= d_nxt;
    hb_r <= hb_nxt;
  end

  // stage 2: knee selection, hard clip slope
  logic signed [BW-1:0]  p;
  logic signed [BW-1:0]  n;
  logic signed [W+18:0]  hp;
  logic signed [W+18:0]  hround;
  logic [EW-1:0]         e_nxt;
  logic signed [BW-1:0]  b2_nxt;
  ashc_pkg::knee_op_t    op2_nxt;
  logic                  v2_r;
  logic [EW-1:0]         e2_r;
  logic signed [BW-1:0]  b2_r;
  ashc_pkg::knee_op_t    op2_r;

  always_comb begin
    p      = $signed(BW'(cfg.pos_thr) << (F - 15));
    n      = $signed(BW'(cfg.neg_thr) << (F - 15));
    hp     = d_r * $signed({1'b0, cfg.post_slope});
    hround = hp + $signed((W+19)'(16384));
    e_nxt   = '0;
    b2_nxt  = xs_r;
    op2_nxt = ashc_pkg::OP_PASS;
    if (cfg.clip_mode) begin
      b2_nxt = hb_r + BW'(hround >>> 15);
    end else if (xs_r > p) begin
      e_nxt   = EW'(xs_r - p);
      b2_nxt  = p;
      op2_nxt = ashc_pkg::OP_ADD;
    end else if (xs_r < -n) begin
      e_nxt   = EW'(-n - xs_r);
      b2_nxt  = -n;
      op2_nxt = ashc_pkg::OP_SUB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    e2_r  <= e_nxt;
    b2_r  <= b2_nxt;
    op2_r <= op2_nxt;
  end

  // stage 3: excess moved to Q.24 and squared
  logic [EKW-1:0]        ek;
  logic                  v3_r;
  logic [2*EKW-1:0]      sq_r;
  logic [EW-1:0]         e3_r;
  logic signed [BW-1:0]  b3_r;
  ashc_pkg::knee_op_t    op3_r;

  if (F > KF) begin : g_ek_round
    assign ek = EKW'((e2_r + (EW'(1) << (F - KF - 1))) >> (F - KF));
  end else if (F == KF) begin : g_ek_same
    assign ek = EKW'(e2_r);
  end else begin : g_ek_shift
    assign ek = EKW'(e2_r) << (KF - F);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    sq_r  <= ek * ek;
    e3_r  <= e2_r;
    b3_r  <= b2_r;
    op3_r <= op2_r;
  end

  // stage 4: denominator 1 + e^2 and rounded numerator
  logic [2*EKW-1:0]      sqr;
  logic [DW-1:0]         den;
  logic [CW-1:0]         num;
  logic                  v4_r;
  logic [CW-1:0]         rem_r;
  logic [DW-1:0]         den_r;
  logic signed [BW-1:0]  b4_r;
  ashc_pkg::knee_op_t    op4_r;

  always_comb begin
    sqr = sq_r + ((2*EKW)'(1) << (KF - 1));
    den = (DW'(1) << KF) + DW'(sqr >> KF);
    num = (CW'(e3_r) << KF) + CW'(den >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    rem_r <= num;
    den_r <= den;
    b4_r  <= b3_r;
    op4_r <= op3_r;
  end

  assign out_valid = v4_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_base  = b4_r;
  assign out_op    = op4_r;

endmodule

### design/ashc_div_cell.sv
// ashc_div_cell: one restoring-division cell, settles quotient bit K
// carries the item's base value and knee operation alongside
// depends on ashc_pkg (knee_op_t, DW)
`timescale 1ns / 1ps

module ashc_div_cell #(
  parameter int W = 24,
  parameter int K = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [W+35:0]           in_rem,
  input  logic [ashc_pkg::DW-1:0] in_den,
  input  logic [W-1:0]            in_q,
  input  logic signed [W+5:0]     in_base,
  input  ashc_pkg::knee_op_t      in_op,
  output logic                    out_valid,
  output logic [W+35:0]           out_rem,
  output logic [ashc_pkg::DW-1:0] out_den,
  output logic [W-1:0]            out_q,
  output logic signed [W+5:0]     out_base,
  output ashc_pkg::knee_op_t      out_op
);

  localparam int CW = W + 36;

  logic [CW-1:0] dsh;
  logic          ge;
  logic          valid_r;
  logic [CW-1:0] rem_r;
  logic [ashc_pkg::DW-1:0] den_r;
  logic [W-1:0]  q_r;
  logic signed [W+5:0] base_r;
  ashc_pkg::knee_op_t  op_r;

  // trial subtract of the shifted divisor
  assign dsh = CW'(in_den) << K;
  assign ge  = in_rem >= dsh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    rem_r  <= ge ? (in_rem - dsh) : in_rem;
    q_r    <= {in_q[W-2:0], ge};
    den_r  <= in_den;
    base_r <= in_base;
    op_r   <= in_op;
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_q     = q_r;
  assign out_base  = base_r;
  assign out_op    = op_r;

endmodule

### design/asymmetric_soft_hard_clipper.sv
// asymmetric_soft_hard_clipper: top level of the soft/hard waveshaper
// instantiates ashc_regs, ashc_front and a row of ashc_div_cell
// depends on ashc_pkg
//
//   channel  ports                                      handshake
//   input    start, busy, in_sample_in                  taken when start & !busy
//   result   out_valid, out_sample_out                  one-cycle strobe, no stall
//   config   psel, penable, pwrite, paddr, pwdata,      APB write, pready tied high
//            prdata, pready
//
// one item per cycle; busy is always low
// an item passes the five front stages, one divider cell per
// quotient bit (SAMPLE_WIDTH cells), and the output register
// synchronous reset clears all item valids and loads register defaults
// results cannot be held off, so nothing in the pipe ever waits
`timescale 1ns / 1ps

module asymmetric_soft_hard_clipper #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                          out_valid,
  output logic signed [SAMPLE_WIDTH+1:0] out_sample_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int BW  = W + 6;
  localparam int CW  = W + 36;
  localparam int OW  = W + 2;
  localparam int NC  = W;
  localparam int LAT = W + 6;

  ashc_pkg::cfg_t cfg;
  logic           accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // config registers
  ashc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // chain links, index 0 is the front end output
  logic                    c_valid [NC+1];
  logic [CW-1:0]           c_rem   [NC+1];
  logic [ashc_pkg::DW-1:0] c_den   [NC+1];
  logic [W-1:0]            c_q     [NC+1];
  logic signed [BW-1:0]    c_base  [NC+1];
  ashc_pkg::knee_op_t      c_op    [NC+1];

  ashc_front #(.W(W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (accept),
    .in_x      (in_sample_in),
    .out_valid (c_valid[0]),
    .out_rem   (c_rem[0]),
    .out_den   (c_den[0]),
    .out_base  (c_base[0]),
    .out_op    (c_op[0])
  );

  assign c_q[0] = '0;

  // divider row, most significant quotient bit first
  for (genvar i = 0; i < NC; i++) begin : g_cell
    ashc_div_cell #(.W(W), .K(NC - 1 - i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_valid[i]),
      .in_rem    (c_rem[i]),
      .in_den    (c_den[i]),
      .in_q      (c_q[i]),
      .in_base   (c_base[i]),
      .in_op     (c_op[i]),
      .out_valid (c_valid[i+1]),
      .out_rem   (c_rem[i+1]),
      .out_den   (c_den[i+1]),
      .out_q     (c_q[i+1]),
      .out_base  (c_base[i+1]),
      .out_op    (c_op[i+1])
    );
  end

  // apply the knee and saturate
  logic signed [BW:0]   r;
  logic signed [BW:0]   bext;
  logic signed [BW:0]   qext;
  logic signed [OW-1:0] omax;
  logic signed [OW-1:0] omin;
  logic signed [OW-1:0] res_nxt;
  logic                 out_valid_r;
  logic signed [OW-1:0] out_sample_out_r;

  always_comb begin
    omax = {1'b0, {(OW-1){1'b1}}};
    omin = {1'b1, {(OW-1){1'b0}}};
    bext = (BW+1)'(c_base[NC]);
    qext = $signed((BW+1)'(c_q[NC]));
    case (c_op[NC])
      ashc_pkg::OP_ADD: r = bext + qext;
      ashc_pkg::OP_SUB: r = bext - qext;
      default:          r = bext;
    endcase
    if (r > (BW+1)'(omax)) begin
      res_nxt = omax;
    end else if (r < (BW+1)'(omin)) begin
      res_nxt = omin;
    end else begin
      res_nxt = OW'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c_valid[NC];
    end
    out_sample_out_r <= res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_out_r;

`ifndef SYNTHESIS
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted item produced no result");

  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without an accepted item");

  a_drive_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.drive <= ashc_pkg::DRIVE_MAX)
    else $error("drive register above cap");
`endif

endmodule
